// ----- sv/pts_pkg.sv -----
// Shared types and constants for the priority task scheduler.
// No dependencies.
package pts_pkg;

    localparam int NumTasksDef = 16;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_READY   = 2'd2,
        ST_FREE    = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        M_TICK     = 3'd0,
        M_SCHED    = 3'd1,
        M_CREATE   = 3'd2,
        M_BLOCK    = 3'd3,
        M_DELAY    = 3'd4,
        M_UNBLOCK  = 3'd5,
        M_NOP6     = 3'd6,
        M_NOP7     = 3'd7
    } t_mode;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZPRIO   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item, start op
        logic scan_clr;  // reset scan pointer and best
        logic scan_step; // process one slot of the scan
        logic finish;    // apply end-of-scan action
        logic emit;      // load output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last; // current step is last slot
    } t_sts;

endpackage

// ----- sv/pts_if.sv -----
// Valid/ready channel interface for scheduler items.
// Parameterized by payload type; no package dependency.
interface pts_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/priority_task_scheduler.sv -----
// Priority task scheduler: a kernel task table in hardware with
// NUM_TASKS slots plus an idle slot. Each item passes a capture step, a
// setup step, a scan of the slots one at a time through the shared scan
// unit, and an apply step, which waits while the output register is still
// full. Every item gives exactly one result, held in an output register
// until taken. Depends on pts_pkg, pts_if, pts_ctrl, pts_dp.
module priority_task_scheduler import pts_pkg::*; #(
    parameter int NUM_TASKS = NumTasksDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pts_if.sink   in_ch,
    pts_if.source out_ch
);
    t_cmd cmd;
    t_sts sts;
    logic out_busy;

    pts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_out_busy(out_busy), .i_sts(sts), .o_cmd(cmd)
    );

    pts_dp #(.NUM_TASKS(NUM_TASKS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_sts(sts),
        .i_mode(in_ch.data.mode), .i_prio_in(in_ch.data.prio_in),
        .i_task_id(in_ch.data.task_id), .i_wake_tic(in_ch.data.wake_tic),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid), .o_out_busy(out_busy),
        .o_running_task(out_ch.data.running_task),
        .o_created_slot(out_ch.data.created_slot),
        .o_status(out_ch.data.status),
        .o_queried_blocked(out_ch.data.queried_blocked),
        .o_tick_now(out_ch.data.tick_now)
    );
endmodule

// ----- sv/pts_ctrl.sv -----
// Controller state machine of the scheduler.
// Depends on pts_pkg.
module pts_ctrl import pts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.scan_clr = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.emit   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE) else $error("load outside idle");
    a_init_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |=> r_state == S_SCAN) else $error("init not followed by scan");
`endif
endmodule

// ----- sv/pts_dp.sv -----
// Datapath: task table, tick counter, scan unit and output register.
// Depends on pts_pkg.
module pts_dp import pts_pkg::*; #(
    parameter int NUM_TASKS = NumTasksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_prio_in,
    input  logic [3:0]  i_task_id,
    input  logic [31:0] i_wake_tic,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic        o_out_busy,
    output logic [4:0]  o_running_task,
    output logic [3:0]  o_created_slot,
    output logic [1:0]  o_status,
    output logic        o_queried_blocked,
    output logic [31:0] o_tick_now
);
    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam logic [CW-1:0] IDLE = CW'(NUM_TASKS);
    localparam logic [IW-1:0] LAST = IW'(NUM_TASKS - 1);

    // Task table
    t_slot_st    r_st   [NUM_TASKS];
    logic [7:0]  r_prio [NUM_TASKS];
    logic [31:0] r_cnt  [NUM_TASKS];
    logic        r_dly  [NUM_TASKS];
    logic [CW-1:0] r_cur;
    logic [31:0] r_tick;

    // Captured item and scan state
    t_mode       r_mode;
    logic [7:0]  r_pin;
    logic [3:0]  r_tid;
    logic [31:0] r_wake;
    logic [IW-1:0] r_ptr;
    logic [IW:0]   r_n;
    logic [7:0]  r_bprio;
    logic [CW-1:0] r_best;
    logic        r_found;

    // Output register
    logic        r_ov;
    logic [4:0]  r_orun;
    logic [3:0]  r_ocr;
    logic [1:0]  r_ost;
    logic        r_oqb;
    logic [31:0] r_otick;

    assign o_sts.scan_last = (r_n == (IW+1)'(NUM_TASKS - 1));
    assign o_out_valid = r_ov;
    assign o_out_busy  = r_ov && !i_out_ready;
    assign o_running_task = r_orun;
    assign o_created_slot = r_ocr;
    assign o_status = r_ost;
    assign o_queried_blocked = r_oqb;
    assign o_tick_now = r_otick;

    logic          cur_task;
    logic [IW-1:0] cur_i;
    logic [IW-1:0] nxt_ptr;
    logic [31:0]   diff;
    t_slot_st      ps;
    logic          tid_ok;
    assign cur_task = (r_cur != IDLE);
    assign cur_i    = r_cur[IW-1:0];
    assign nxt_ptr  = (r_ptr == LAST) ? '0 : r_ptr + 1'b1;
    assign diff     = r_wake - r_tick;
    assign tid_ok   = (int'(r_tid) < NUM_TASKS);
    // State seen by scan: running current slot counts as ready for schedule
    assign ps = (r_mode == M_SCHED && r_st[r_ptr] == ST_RUNNING) ? ST_READY : r_st[r_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_st[k] <= ST_FREE;
                r_prio[k] <= '0;
                r_cnt[k] <= '0;
                r_dly[k] <= 1'b0;
            end
            r_cur  <= IDLE;
            r_tick <= '0;
            r_ov   <= 1'b0;
        end else begin
            // Output valid: set by a new result, cleared by a transfer
            if (i_cmd.finish) r_ov <= 1'b1;
            else if (r_ov && i_out_ready) r_ov <= 1'b0;
            if (i_cmd.load) begin
                r_mode <= t_mode'(i_mode);
                r_pin  <= i_prio_in;
                r_tid  <= i_task_id;
                r_wake <= i_wake_tic;
            end
            if (i_cmd.scan_clr) begin
                r_ptr   <= (cur_task && cur_i != LAST) ? cur_i + 1'b1 : '0;
                r_n     <= '0;
                r_bprio <= '0;
                r_best  <= IDLE;
                r_found <= 1'b0;
                if (r_mode == M_TICK) r_tick <= r_tick + 1'b1;
            end
            // One slot per cycle
            if (i_cmd.scan_step) begin
                r_ptr <= nxt_ptr;
                r_n   <= r_n + 1'b1;
                unique case (r_mode)
                    M_TICK: if (r_dly[r_ptr]) begin
                        r_cnt[r_ptr] <= r_cnt[r_ptr] - 1'b1;
                        if (r_cnt[r_ptr] == 32'd1) begin
                            r_dly[r_ptr] <= 1'b0;
                            r_st[r_ptr]  <= ST_READY;
                        end
                    end
                    M_SCHED: if (ps == ST_READY && r_prio[r_ptr] > r_bprio) begin
                        r_bprio <= r_prio[r_ptr];
                        r_best  <= CW'(r_ptr);
                    end
                    M_CREATE: if (!r_found && r_st[r_ptr] == ST_FREE) begin
                        r_found <= 1'b1;
                        r_best  <= CW'(r_ptr);
                    end
                    default: ;
                endcase
            end
            // Apply and report
            if (i_cmd.finish) begin
                r_ocr <= (r_mode == M_CREATE && r_pin != '0 && r_found) ? 4'(r_best) : '0;
                r_ost <= (r_mode != M_CREATE) ? STAT_OK :
                         (r_pin == '0)        ? STAT_ZPRIO :
                         (!r_found)           ? STAT_FULL : STAT_OK;
                unique case (r_mode)
                    M_SCHED: begin
                        if (cur_task && r_st[cur_i] == ST_RUNNING && r_best != r_cur)
                            r_st[cur_i] <= ST_READY;
                        if (r_best != IDLE) r_st[r_best[IW-1:0]] <= ST_RUNNING;
                        r_cur <= r_best;
                    end
                    M_CREATE: begin
                        if (r_pin != '0 && r_found) begin
                            r_st[r_best[IW-1:0]]   <= ST_READY;
                            r_prio[r_best[IW-1:0]] <= r_pin;
                            r_dly[r_best[IW-1:0]]  <= 1'b0;
                            r_cnt[r_best[IW-1:0]]  <= '0;
                        end
                    end
                    M_BLOCK: if (cur_task) r_st[cur_i] <= ST_BLOCKED;
                    M_DELAY: if (cur_task) begin
                        r_st[cur_i]  <= ST_BLOCKED;
                        r_dly[cur_i] <= 1'b1;
                        r_cnt[cur_i] <= (diff == '0 || diff[31]) ? 32'd1 : diff;
                    end
                    M_UNBLOCK: if (tid_ok && r_st[IW'(r_tid)] == ST_BLOCKED)
                        r_st[IW'(r_tid)] <= ST_READY;
                    default: ;
                endcase
            end
        end
    end

    // Queried-blocked status reflects the table after this item
    logic qb_pre, qb_post;
    assign qb_pre = tid_ok && r_st[IW'(r_tid)] == ST_BLOCKED;
    always_comb begin
        qb_post = qb_pre;
        if (tid_ok && cur_task && IW'(r_tid) == cur_i
            && (r_mode == M_BLOCK || r_mode == M_DELAY)) qb_post = 1'b1;
        if (r_mode == M_UNBLOCK) qb_post = 1'b0;
        if (r_mode == M_CREATE && r_pin != '0 && r_found && r_best == CW'(r_tid))
            qb_post = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_oqb   <= qb_post;
            r_orun  <= 5'((r_mode == M_SCHED) ? r_best : r_cur);
            r_otick <= r_tick;
        end
    end

`ifndef SYNTHESIS
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= IDLE) else $error("current slot out of range");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_ov) else $error("emit lost");
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_ov && !i_out_ready)) else $error("output overwritten");
`endif
endmodule
